/* design/assert_macros.svh */
// Assertion macros used by the BSON key lookup RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge while reset is released.
`define BKLP_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Check a property on every rising edge, reset included.
`define BKLP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define BKLP_ASSERT_RST(lbl, clk, rstn, prop, msg)
`define BKLP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* design/bklp_pkg.sv */
// Shared types and constants of the BSON key lookup parser.
package bklp_pkg;

    localparam int KEY_BYTES_MAX_DEF = 32;
    localparam int KEY_LEN_W         = 6;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 64;
    localparam int POS_W             = 31;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 3'd1;

    // Final status codes
    localparam logic [2:0] ST_FOUND       = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd1;
    localparam logic [2:0] ST_TRUNC       = 3'd2;
    localparam logic [2:0] ST_UNKNOWN     = 3'd3;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]       value_byte;
        logic             value_valid;
        logic [7:0]       element_type;
        logic [7:0]       binary_subtype;
        logic             done_res;
        logic [2:0]       status;
        logic [POS_W-1:0] end_position;
    } out_beat_t;

endpackage

/* design/bson_key_lookup_parser_top.sv */
// Top level of the BSON key lookup parser: input register, key registers, parser.
//
// Walks a BSON document fed one byte per beat on the s_ channel and looks for
// the element whose key equals the configured key (cfg register 0 is the key
// length, registers 1 to 4 hold key bytes 0 to 31, first byte in the low bits;
// write them while the block is idle). A beat with first_byte set restarts the
// search at size byte 0. When the key matches, every value byte goes out as its
// own m_ beat (strings include their trailing NUL, numbers LSB first, bool as
// 0 or 1); the last beat of a search carries done_res, the status, the element
// type, the binary subtype and the offset just past the parsed data. Searches
// that end without a value give one final beat. Bytes after the final beat are
// dropped until the next first_byte. Keys longer than KEY_BYTES_MAX never match.
// Throughput is one document byte per clock while m_ready is high; each byte is a
// single state update and key-byte compare between the input register and the
// result register. An s_ beat goes through the input register and then the result
// register to its m_ beat; m_ready low stalls the input after one beat of buffering.
module bson_key_lookup_parser_top #(
    parameter int KEY_BYTES_MAX = bklp_pkg::KEY_BYTES_MAX_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Document byte channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  bklp_pkg::in_beat_t               s_data,
    // Result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output bklp_pkg::out_beat_t              m_data,
    // Configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bklp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bklp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bklp_pkg::*;

    logic                          held_valid;
    in_beat_t                      held_data;
    logic                          take;
    logic [KEY_LEN_W-1:0]          key_length;
    logic [KEY_BYTES_MAX-1:0][7:0] key_bytes;

    // Hold one document byte; advance it when the result side can take its beat
    bklp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (take),
        .held_valid (held_valid),
        .held_data  (held_data)
    );

    // Searched key and its length
    bklp_key_regs #(
        .KEY_BYTES_MAX (KEY_BYTES_MAX)
    ) u_key_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .key_length (key_length),
        .key_bytes  (key_bytes)
    );

    // Step the document walk and register the result beat
    bklp_parser #(
        .KEY_BYTES_MAX (KEY_BYTES_MAX)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (held_valid),
        .in_data    (held_data),
        .take       (take),
        .key_length (key_length),
        .key_bytes  (key_bytes),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

/* design/bklp_in_stage.sv */
// Input register of the BSON key lookup parser.
module bklp_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bklp_pkg::in_beat_t  s_data,
    input  logic                take,
    output logic                held_valid,
    output bklp_pkg::in_beat_t  held_data
);
    import bklp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_beat_t data_reg;

    // Refill in the same cycle the held beat moves on
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign held_valid = valid_reg;
    assign held_data  = data_reg;

endmodule

/* design/bklp_key_regs.sv */
// Configuration registers holding the searched key and its length.
module bklp_key_regs #(
    parameter int KEY_BYTES_MAX = bklp_pkg::KEY_BYTES_MAX_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bklp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bklp_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic [bklp_pkg::KEY_LEN_W-1:0]       key_length,
    output logic [KEY_BYTES_MAX-1:0][7:0]        key_bytes
);
    import bklp_pkg::*;

    logic [KEY_LEN_W-1:0]          key_length_reg;
    logic [KEY_BYTES_MAX-1:0][7:0] key_bytes_reg;
    logic                          wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_length_reg <= '0;
        end else if (wr && cfg_index == CFG_KEY_LENGTH) begin
            key_length_reg <= cfg_data[KEY_LEN_W-1:0];
        end
    end

    // Each key byte lives in one lane of one key word; bytes past the limit are not kept
    for (genvar k = 0; k < KEY_BYTES_MAX; k++) begin : g_key_byte
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                key_bytes_reg[k] <= '0;
            end else if (wr && cfg_index == CFG_KEY_WORD_0 + CFG_IDX_W'(k / 8)) begin
                key_bytes_reg[k] <= cfg_data[(k % 8)*8 +: 8];
            end
        end
    end

    assign key_length = key_length_reg;
    assign key_bytes  = key_bytes_reg;

endmodule

/* design/bklp_parser.sv */
// Per-byte BSON walk: parse state, key compare and result register.
`include "assert_macros.svh"

module bklp_parser #(
    parameter int KEY_BYTES_MAX = bklp_pkg::KEY_BYTES_MAX_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    input  bklp_pkg::in_beat_t               in_data,
    output logic                             take,
    input  logic [bklp_pkg::KEY_LEN_W-1:0]   key_length,
    input  logic [KEY_BYTES_MAX-1:0][7:0]    key_bytes,
    output logic                             m_valid,
    input  logic                             m_ready,
    output bklp_pkg::out_beat_t              m_data
);
    import bklp_pkg::*;

    localparam int KIDX_W = $clog2(KEY_BYTES_MAX + 2);
    localparam int KSEL_W = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam logic [2:0] PH_SIZE  = 3'd0;
    localparam logic [2:0] PH_TYPE  = 3'd1;
    localparam logic [2:0] PH_KEY   = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_SUB   = 3'd4;
    localparam logic [2:0] PH_VALUE = 3'd5;
    localparam logic [2:0] PH_DONE  = 3'd6;

    localparam logic [7:0] T_STRING = 8'h02;
    localparam logic [7:0] T_DOC    = 8'h03;
    localparam logic [7:0] T_ARRAY  = 8'h04;
    localparam logic [7:0] T_BINARY = 8'h05;
    localparam logic [7:0] T_UNDEF  = 8'h06;
    localparam logic [7:0] T_BOOL   = 8'h08;
    localparam logic [7:0] T_UTC    = 8'h09;
    localparam logic [7:0] T_NULL   = 8'h0A;
    localparam logic [7:0] T_INT32  = 8'h10;
    localparam logic [7:0] T_TSTAMP = 8'h11;
    localparam logic [7:0] T_INT64  = 8'h12;
    localparam logic [7:0] T_MAXKEY = 8'h7F;
    localparam logic [7:0] T_MINKEY = 8'hFF;
    localparam logic [7:0] BOOL_TRUE = 8'h01;

    function automatic logic known_type(input logic [7:0] t);
        return t == T_STRING || t == T_BINARY || t == T_UNDEF || t == T_BOOL ||
               t == T_UTC || t == T_NULL || t == T_INT32 || t == T_TSTAMP ||
               t == T_INT64 || t == T_MAXKEY || t == T_MINKEY;
    endfunction

    function automatic logic [31:0] fixed_len(input logic [7:0] t);
        logic [31:0] len;
        len = 32'd0;
        if (t == T_BOOL) len = 32'd1;
        else if (t == T_INT32) len = 32'd4;
        else if (t == T_UTC || t == T_TSTAMP || t == T_INT64) len = 32'd8;
        return len;
    endfunction

    // Parse state
    logic [2:0]        phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [31:0]       size_reg, size_next;
    logic [31:0]       rem_reg, rem_next;
    logic [KIDX_W-1:0] kidx_reg, kidx_next;
    logic              keq_reg, keq_next;
    logic [7:0]        ctype_reg, ctype_next;
    logic              match_reg, match_next;
    logic              fin_reg, fin_next;
    logic [1:0]        pcnt_reg, pcnt_next;
    logic [7:0]        sub_reg, sub_next;

    // Result register
    logic      out_valid_reg, out_valid_next;
    out_beat_t out_data_reg, out_data_next;

    // State as seen by this byte (restart on first_byte)
    logic [2:0]        c_phase;
    logic [POS_W-1:0]  c_pos;
    logic [31:0]       c_size;
    logic [31:0]       c_rem;
    logic [KIDX_W-1:0] c_kidx;
    logic              c_keq;
    logic [7:0]        c_ctype;
    logic              c_match;
    logic              c_fin;
    logic [1:0]        c_pcnt;
    logic [7:0]        c_sub;

    logic [7:0]        b;
    logic [POS_W-1:0]  pos_inc;
    logic              done;
    logic              elem_end;
    logic              vv;
    logic [7:0]        vb;
    logic [2:0]        st;
    logic              emit;
    logic              step_done;
    logic              key_mismatch;
    logic [31:0]       or_word;

    assign take = in_valid && (!out_valid_reg || m_ready);
    assign b    = in_data.data_byte;

    always_comb begin
        if (in_data.first_byte) begin
            c_phase = PH_SIZE;
            c_pos   = '0;
            c_size  = '0;
            c_rem   = '0;
            c_kidx  = '0;
            c_keq   = 1'b1;
            c_ctype = '0;
            c_match = 1'b0;
            c_fin   = 1'b0;
            c_pcnt  = '0;
            c_sub   = '0;
        end else begin
            c_phase = phase_reg;
            c_pos   = pos_reg;
            c_size  = size_reg;
            c_rem   = rem_reg;
            c_kidx  = kidx_reg;
            c_keq   = keq_reg;
            c_ctype = ctype_reg;
            c_match = match_reg;
            c_fin   = fin_reg;
            c_pcnt  = pcnt_reg;
            c_sub   = sub_reg;
        end
    end

    always_comb begin
        pos_inc = (c_pos == POS_MAX) ? c_pos : c_pos + 1'b1;
        key_mismatch = c_kidx < KIDX_W'(KEY_BYTES_MAX) &&
                       KEY_LEN_W'(c_kidx) < key_length &&
                       key_bytes[c_kidx[KSEL_W-1:0]] != b;

        phase_next = c_phase;
        pos_next   = c_pos;
        size_next  = c_size;
        rem_next   = c_rem;
        kidx_next  = c_kidx;
        keq_next   = c_keq;
        ctype_next = c_ctype;
        match_next = c_match;
        fin_next   = c_fin;
        pcnt_next  = c_pcnt;
        sub_next   = c_sub;
        done       = 1'b0;
        elem_end   = 1'b0;
        vv         = 1'b0;
        vb         = '0;
        st         = ST_FOUND;
        or_word    = '0;

        if (!c_fin) begin
            pos_next = pos_inc;
            unique case (c_phase)
                PH_SIZE: begin
                    or_word   = 32'(b) << {c_pos[1:0], 3'b000};
                    size_next = c_size | or_word;
                    if (c_pos >= POS_W'(3)) begin
                        if (size_next[31] || size_next <= 32'(pos_inc)) begin
                            done = 1'b1;
                            st   = ST_NOT_FOUND;
                        end else begin
                            phase_next = PH_TYPE;
                        end
                    end
                end
                PH_TYPE: begin
                    match_next = 1'b0;
                    sub_next   = '0;
                    if (b == 8'h00) begin
                        done = 1'b1;
                        st   = ST_NOT_FOUND;
                    end else begin
                        ctype_next = b;
                        if (b == T_DOC || b == T_ARRAY) begin
                            done = 1'b1;
                            st   = ST_UNSUPPORTED;
                        end else if (!known_type(b)) begin
                            done = 1'b1;
                            st   = ST_UNKNOWN;
                        end else begin
                            phase_next = PH_KEY;
                            kidx_next  = '0;
                            keq_next   = 1'b1;
                        end
                    end
                end
                PH_KEY: begin
                    if (b != 8'h00) begin
                        if (key_mismatch) keq_next = 1'b0;
                        if (c_kidx <= KIDX_W'(KEY_BYTES_MAX)) kidx_next = c_kidx + 1'b1;
                    end else begin
                        match_next = c_keq && KEY_LEN_W'(c_kidx) == key_length &&
                                     key_length <= KEY_LEN_W'(KEY_BYTES_MAX);
                        if (c_ctype == T_STRING || c_ctype == T_BINARY) begin
                            phase_next = PH_LEN;
                            pcnt_next  = '0;
                            rem_next   = '0;
                        end else begin
                            rem_next = fixed_len(c_ctype);
                            if (rem_next == 32'd0) elem_end = 1'b1;
                            else phase_next = PH_VALUE;
                        end
                    end
                end
                PH_LEN: begin
                    or_word   = 32'(b) << {c_pcnt, 3'b000};
                    rem_next  = c_rem | or_word;
                    pcnt_next = c_pcnt + 1'b1;
                    if (c_pcnt == 2'd3) begin
                        if (c_ctype == T_BINARY) phase_next = PH_SUB;
                        else if (rem_next == 32'd0) elem_end = 1'b1;
                        else phase_next = PH_VALUE;
                    end
                end
                PH_SUB: begin
                    sub_next = b;
                    if (c_rem == 32'd0) elem_end = 1'b1;
                    else phase_next = PH_VALUE;
                end
                PH_VALUE: begin
                    if (c_match) begin
                        vv = 1'b1;
                        vb = (c_ctype == T_BOOL) ? {7'd0, b == BOOL_TRUE} : b;
                    end
                    rem_next = c_rem - 1'b1;
                    if (rem_next == 32'd0) elem_end = 1'b1;
                end
                default: begin
                end
            endcase

            if (elem_end) begin
                if (match_next) begin
                    done = 1'b1;
                    st   = ST_FOUND;
                end else if (c_size[31] || c_size <= 32'(pos_inc)) begin
                    done = 1'b1;
                    st   = ST_NOT_FOUND;
                end else begin
                    phase_next = PH_TYPE;
                end
            end
            if (!done && in_data.last_byte) begin
                done = 1'b1;
                st   = ST_TRUNC;
            end
            if (done) begin
                fin_next   = 1'b1;
                phase_next = PH_DONE;
            end
        end

        step_done = done;
        emit      = !c_fin && (done || vv);

        out_data_next.value_byte     = vb;
        out_data_next.value_valid    = vv;
        out_data_next.element_type   = (match_next || st == ST_UNKNOWN ||
                                        st == ST_UNSUPPORTED) ? ctype_next : 8'h00;
        out_data_next.binary_subtype = (match_next && ctype_next == T_BINARY) ?
                                       sub_next : 8'h00;
        out_data_next.done_res       = done;
        out_data_next.status         = done ? st : ST_FOUND;
        out_data_next.end_position   = done ? pos_next : '0;

        if (take) out_valid_next = emit;
        else if (m_ready) out_valid_next = 1'b0;
        else out_valid_next = out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SIZE;
            pos_reg       <= '0;
            size_reg      <= '0;
            rem_reg       <= '0;
            kidx_reg      <= '0;
            keq_reg       <= 1'b1;
            ctype_reg     <= '0;
            match_reg     <= 1'b0;
            fin_reg       <= 1'b0;
            pcnt_reg      <= '0;
            sub_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                size_reg  <= size_next;
                rem_reg   <= rem_next;
                kidx_reg  <= kidx_next;
                keq_reg   <= keq_next;
                ctype_reg <= ctype_next;
                match_reg <= match_next;
                fin_reg   <= fin_next;
                pcnt_reg  <= pcnt_next;
                sub_reg   <= sub_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && emit) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    `BKLP_ASSERT_RST(a_mid_result_is_value, aclk, aresetn,
        (out_valid_reg && !out_data_reg.done_res) |-> (out_data_reg.value_valid &&
        out_data_reg.status == ST_FOUND && out_data_reg.end_position == '0),
        "non-final result must carry a value byte only")
    `BKLP_ASSERT_ALWAYS(a_fin_parks_phase, aclk,
        fin_reg |-> (phase_reg == PH_DONE), "finished search must sit in done phase")
    `BKLP_ASSERT_ALWAYS(a_value_has_bytes, aclk,
        (phase_reg == PH_VALUE) |-> (rem_reg != 32'd0),
        "value phase entered with nothing left to read")
    `BKLP_ASSERT_RST(a_done_sets_fin, aclk, aresetn,
        (take && step_done) |=> (fin_reg && out_valid_reg),
        "final result must end the search and be presented")

endmodule
